// ----- hw/rtl/anj_pkg.sv -----
// anj_pkg: shared types, command codes, state encoding and saturating helpers
// for the averaged nodal jacobian block. No dependencies.
package anj_pkg;

	// default sizing of the mesh storage
	localparam int MAX_ELEMENTS_DEF          = 1024;
	localparam int MAX_NODES_DEF             = 2048;
	localparam int MAX_NODES_PER_ELEMENT_DEF = 8;

	// fixed field widths
	localparam int CMD_W   = 3;
	localparam int EIDX_W  = 10;
	localparam int VAL_W   = 32;
	localparam int NODE_W  = 11;
	localparam int NPORTS  = 8;
	localparam int SUM_W   = 48;
	localparam int ACC_W   = 64;
	localparam int AVG_W   = 35;
	localparam int CFGI_W  = 2;
	localparam int CFGD_W  = 12;
	localparam int NE_W    = 11;
	localparam int NN_W    = 12;
	localparam int NPE_W   = 4;
	localparam int DIVC_W  = 6;

	// 1.0 in Q8.24
	localparam logic signed [VAL_W-1:0] ONE_Q24 = 32'sh0100_0000;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR   = 3'd0,
		CMD_ADD     = 3'd1,
		CMD_SET     = 3'd2,
		CMD_COMPUTE = 3'd3,
		CMD_READ    = 3'd4
	} cmd_t;

	// configuration register indexes
	typedef enum logic [CFGI_W-1:0] {
		CFG_NUM_ELEMENTS = 2'd0,
		CFG_NUM_NODES    = 2'd1,
		CFG_NPE          = 2'd2
	} cfg_idx_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_CLR,
		ST_IDLE,
		ST_ADD_CONN,
		ST_ADD_RD,
		ST_ADD_UPD,
		ST_CZ,
		ST_CE_RD,
		ST_CE_MUL,
		ST_CK_RD,
		ST_CK_ID,
		ST_CK_UPD,
		ST_NM_RD,
		ST_NM_CHK,
		ST_NM_DIV,
		ST_AV_EL,
		ST_AV_RD,
		ST_AV_ID,
		ST_AV_ADD,
		ST_AV_DIV,
		ST_RD_OUT
	} state_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// 48-bit volume sum plus a 32-bit volume, saturated
	function automatic logic [SUM_W-1:0] sat_add48(input logic [SUM_W-1:0] a,
			input logic [VAL_W-1:0] b);
		logic [SUM_W:0] s;
		s = {a[SUM_W-1], a} + {{(SUM_W-VAL_W+1){b[VAL_W-1]}}, b};
		if (s[SUM_W] != s[SUM_W-1])
			return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		return s[SUM_W-1:0];
	endfunction

	// 64-bit accumulate, saturated to the signed 64-bit range
	function automatic logic [ACC_W-1:0] sat_add64(input logic [ACC_W-1:0] a,
			input logic [ACC_W-1:0] b);
		logic [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1])
			return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		return s[ACC_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/anj_ram.sv -----
// anj_ram: generic single write port, single read port ram with registered read.
// No dependencies.
module anj_ram #(
	parameter int W = 32,
	parameter int D = 1024,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// registered read, holds between reads
	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/anj_div.sv -----
// anj_div: shared restoring divider, signed 64-bit dividend by positive 48-bit
// divisor, one quotient bit per cycle, quotient saturated to 32 bits. Uses anj_pkg.
module anj_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [anj_pkg::ACC_W-1:0]      dividend,
	input  logic [anj_pkg::SUM_W-1:0]      divisor,
	output anj_pkg::div_stat_t             stat,
	output logic [anj_pkg::VAL_W-1:0]      quot
);
	import anj_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DIVC_W-1:0] cnt_q;
	logic [SUM_W-1:0]  rem_q;
	logic [ACC_W-1:0]  quo_q;
	logic [SUM_W-1:0]  dvs_q;
	logic              neg_q;
	logic [SUM_W:0]    trial;
	logic              fits;

	// one restoring step
	always_comb begin
		trial = {rem_q, quo_q[ACC_W-1]};
		fits  = (trial >= {1'b0, dvs_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {DIVC_W{1'b1}}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operands and partial results
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[ACC_W-1] ? (~dividend + 1'b1) : dividend;
			neg_q <= dividend[ACC_W-1];
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? SUM_W'(trial - {1'b0, dvs_q}) : trial[SUM_W-1:0];
			quo_q <= {quo_q[ACC_W-2:0], fits};
		end
	end

	// sign and saturation of the magnitude quotient
	always_comb begin
		if (neg_q) begin
			if (quo_q > 64'h0000_0000_8000_0000)
				quot = 32'h8000_0000;
			else
				quot = VAL_W'(~quo_q + 1'b1);
		end else begin
			if (quo_q > 64'h0000_0000_7fff_ffff)
				quot = 32'h7fff_ffff;
			else
				quot = quo_q[VAL_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- hw/rtl/average_nodal_jacobian_top.sv -----
// average_nodal_jacobian_top: mesh storage, command sequencer and datapath for
// volume-weighted nodal jacobian averaging. Uses anj_pkg, anj_ram, anj_div.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall  | command, element_index, value, node_0..node_7
//  out     | output    | out_valid / out_stall| averaged_jacobian
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// after reset the node volume sums are swept to zero, no input taken
// set_jacobian is written from idle; read waits in the output handoff while the output register is held by out_stall
// add_element stores all MAX_NODES_PER_ELEMENT node slots, then adds the volume into nodes_per_element node sums
// clear_mesh zeroes the first num_nodes node volume sums
// compute is bounded by the shared divider and by the node memories,
// which have one read and one write port each
module average_nodal_jacobian_top #(
	parameter int MAX_ELEMENTS          = anj_pkg::MAX_ELEMENTS_DEF,
	parameter int MAX_NODES             = anj_pkg::MAX_NODES_DEF,
	parameter int MAX_NODES_PER_ELEMENT = anj_pkg::MAX_NODES_PER_ELEMENT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [anj_pkg::CMD_W-1:0]    command,
	input  logic [anj_pkg::EIDX_W-1:0]   element_index,
	input  logic [anj_pkg::VAL_W-1:0]    value,
	input  logic [anj_pkg::NODE_W-1:0]   node_0,
	input  logic [anj_pkg::NODE_W-1:0]   node_1,
	input  logic [anj_pkg::NODE_W-1:0]   node_2,
	input  logic [anj_pkg::NODE_W-1:0]   node_3,
	input  logic [anj_pkg::NODE_W-1:0]   node_4,
	input  logic [anj_pkg::NODE_W-1:0]   node_5,
	input  logic [anj_pkg::NODE_W-1:0]   node_6,
	input  logic [anj_pkg::NODE_W-1:0]   node_7,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [anj_pkg::VAL_W-1:0]    averaged_jacobian,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [anj_pkg::CFGI_W-1:0]   cfg_index,
	input  logic [anj_pkg::CFGD_W-1:0]   cfg_data
);
	import anj_pkg::*;

	localparam int EA_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int NA_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CD   = MAX_ELEMENTS * MAX_NODES_PER_ELEMENT;
	localparam int CA_W = (CD > 1) ? $clog2(CD) : 1;
	localparam int EC_W = $clog2(MAX_ELEMENTS + 1);
	localparam int NC_W = $clog2(MAX_NODES + 1);

	// configuration registers
	logic [NE_W-1:0]  num_elements_q;
	logic [NN_W-1:0]  num_nodes_q;
	logic [NPE_W-1:0] npe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_elements_q <= NE_W'(1024);
			num_nodes_q    <= NN_W'(2048);
			npe_q          <= NPE_W'(8);
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_NUM_ELEMENTS: num_elements_q <= cfg_data[NE_W-1:0];
				CFG_NUM_NODES:    num_nodes_q    <= cfg_data;
				CFG_NPE:          npe_q          <= cfg_data[NPE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// effective counts, clamped to the storage
	logic [EC_W-1:0]  ne_eff;
	logic [NC_W-1:0]  nn_eff;
	logic [NPE_W-1:0] npe_eff;

	always_comb begin
		ne_eff = (32'(num_elements_q) > 32'(MAX_ELEMENTS)) ? EC_W'(MAX_ELEMENTS)
			: EC_W'(num_elements_q);
		nn_eff = (32'(num_nodes_q) > 32'(MAX_NODES)) ? NC_W'(MAX_NODES)
			: NC_W'(num_nodes_q);
		if (npe_q == '0)
			npe_eff = NPE_W'(1);
		else if (32'(npe_q) > 32'(MAX_NODES_PER_ELEMENT))
			npe_eff = NPE_W'(MAX_NODES_PER_ELEMENT);
		else
			npe_eff = npe_q;
	end

	// sequencer and datapath registers
	state_t            state_q, state_d;
	logic [EC_W-1:0]   cnt_e_q;
	logic [NC_W-1:0]   cnt_n_q;
	logic [NC_W-1:0]   clr_lim_q;
	logic [NPE_W-1:0]  k_q;
	logic [EIDX_W-1:0] elem_q;
	logic [VAL_W-1:0]  value_q;
	logic [NODE_W-1:0] node_q [NPORTS];
	logic [NODE_W-1:0] id_q;
	logic [ACC_W-1:0]  p_q;
	logic [AVG_W-1:0]  sum_q;
	logic              rd_bad_q;
	logic              out_valid_q;
	logic [VAL_W-1:0]  out_data_q;

	// memory ports
	logic              cn_we, cn_re;
	logic [CA_W-1:0]   cn_waddr, cn_raddr;
	logic [NODE_W-1:0] cn_wdata, cn_rdata;
	logic              vol_we, jac_we, ej_re;
	logic [EA_W-1:0]   ej_waddr, ej_raddr;
	logic [VAL_W-1:0]  vol_rdata, jac_rdata;
	logic              res_we, res_re;
	logic [EA_W-1:0]   res_waddr, res_raddr;
	logic [VAL_W-1:0]  res_rdata;
	logic              ns_we, ns_re;
	logic [NA_W-1:0]   ns_waddr, ns_raddr;
	logic [SUM_W-1:0]  ns_wdata, ns_rdata;
	logic              na_we, na_re;
	logic [NA_W-1:0]   na_waddr, na_raddr;
	logic [ACC_W-1:0]  na_wdata, na_rdata;

	// shared divider
	logic              div_start;
	logic [ACC_W-1:0]  div_dividend;
	logic [SUM_W-1:0]  div_divisor;
	div_stat_t         div_st;
	logic [VAL_W-1:0]  div_quot;

	// decoded helpers
	logic              in_acc;
	logic              in_elem_ok;
	logic [NODE_W-1:0] add_id;
	logic              add_id_ok;
	logic              cn_id_ok;
	logic [CA_W-1:0]   cn_addr_run;
	logic [CA_W-1:0]   cn_addr_add;

	assign in_acc      = in_valid && !in_stall;
	assign in_elem_ok  = 32'(element_index) < 32'(MAX_ELEMENTS);
	assign add_id      = node_q[k_q[2:0]];
	assign add_id_ok   = 32'(add_id) < 32'(nn_eff);
	assign cn_id_ok    = 32'(cn_rdata) < 32'(nn_eff);
	assign cn_addr_run = CA_W'(cnt_e_q) * CA_W'(MAX_NODES_PER_ELEMENT) + CA_W'(k_q);
	assign cn_addr_add = CA_W'(elem_q) * CA_W'(MAX_NODES_PER_ELEMENT) + CA_W'(k_q);

	// next state and memory controls
	always_comb begin
		state_d      = state_q;
		cn_we        = 1'b0;
		cn_re        = 1'b0;
		cn_waddr     = cn_addr_add;
		cn_raddr     = cn_addr_run;
		cn_wdata     = add_id;
		vol_we       = 1'b0;
		jac_we       = 1'b0;
		ej_re        = 1'b0;
		ej_waddr     = EA_W'(element_index);
		ej_raddr     = EA_W'(cnt_e_q);
		res_we       = 1'b0;
		res_re       = 1'b0;
		res_waddr    = EA_W'(cnt_e_q);
		res_raddr    = EA_W'(element_index);
		ns_we        = 1'b0;
		ns_re        = 1'b0;
		ns_waddr     = NA_W'(cnt_n_q);
		ns_raddr     = NA_W'(cnt_n_q);
		ns_wdata     = '0;
		na_we        = 1'b0;
		na_re        = 1'b0;
		na_waddr     = NA_W'(cnt_n_q);
		na_raddr     = NA_W'(cnt_n_q);
		na_wdata     = '0;
		div_start    = 1'b0;
		div_dividend = na_rdata;
		div_divisor  = ns_rdata;
		case (state_q)
			// zero the node volume sums
			ST_CLR: begin
				if (cnt_n_q == clr_lim_q)
					state_d = ST_IDLE;
				else
					ns_we = 1'b1;
			end
			ST_IDLE: begin
				if (in_acc) begin
					case (cmd_t'(command))
						CMD_CLEAR: state_d = ST_CLR;
						CMD_ADD: begin
							if (in_elem_ok) begin
								vol_we  = 1'b1;
								state_d = ST_ADD_CONN;
							end
						end
						CMD_SET: jac_we = in_elem_ok;
						CMD_COMPUTE: state_d = ST_CZ;
						CMD_READ: begin
							res_re  = in_elem_ok;
							state_d = ST_RD_OUT;
						end
						default: ;
					endcase
				end
			end
			// store the node list
			ST_ADD_CONN: begin
				cn_we = 1'b1;
				if (32'(k_q) == MAX_NODES_PER_ELEMENT - 1)
					state_d = ST_ADD_RD;
			end
			// volume scatter into node sums
			ST_ADD_RD: begin
				ns_raddr = NA_W'(add_id);
				if (k_q == npe_eff)
					state_d = ST_IDLE;
				else if (add_id_ok) begin
					ns_re   = 1'b1;
					state_d = ST_ADD_UPD;
				end
			end
			ST_ADD_UPD: begin
				ns_we    = 1'b1;
				ns_waddr = NA_W'(add_id);
				ns_wdata = sat_add48(ns_rdata, value_q);
				state_d  = ST_ADD_RD;
			end
			// clear the nodal accumulators
			ST_CZ: begin
				if (cnt_n_q == nn_eff)
					state_d = ST_CE_RD;
				else
					na_we = 1'b1;
			end
			// per element volume times jacobian
			ST_CE_RD: begin
				if (cnt_e_q == ne_eff)
					state_d = ST_NM_RD;
				else begin
					ej_re   = 1'b1;
					state_d = ST_CE_MUL;
				end
			end
			ST_CE_MUL: state_d = ST_CK_RD;
			ST_CK_RD: begin
				if (k_q == npe_eff)
					state_d = ST_CE_RD;
				else begin
					cn_re   = 1'b1;
					state_d = ST_CK_ID;
				end
			end
			ST_CK_ID: begin
				na_raddr = NA_W'(cn_rdata);
				if (cn_id_ok) begin
					na_re   = 1'b1;
					state_d = ST_CK_UPD;
				end else
					state_d = ST_CK_RD;
			end
			ST_CK_UPD: begin
				na_we    = 1'b1;
				na_waddr = NA_W'(id_q);
				na_wdata = sat_add64(na_rdata, p_q);
				state_d  = ST_CK_RD;
			end
			// normalize each node by its volume sum, 1.0 where the sum is not positive
			ST_NM_RD: begin
				if (cnt_n_q == nn_eff)
					state_d = ST_AV_EL;
				else begin
					ns_re   = 1'b1;
					na_re   = 1'b1;
					state_d = ST_NM_CHK;
				end
			end
			ST_NM_CHK: begin
				if (!ns_rdata[SUM_W-1] && ns_rdata != '0) begin
					div_start = 1'b1;
					state_d   = ST_NM_DIV;
				end else begin
					na_we    = 1'b1;
					na_wdata = {{(ACC_W-VAL_W){ONE_Q24[VAL_W-1]}}, ONE_Q24};
					state_d  = ST_NM_RD;
				end
			end
			ST_NM_DIV: begin
				na_wdata = {{(ACC_W-VAL_W){div_quot[VAL_W-1]}}, div_quot};
				if (div_st.done) begin
					na_we   = 1'b1;
					state_d = ST_NM_RD;
				end
			end
			// gather and average per element
			ST_AV_EL: begin
				if (cnt_e_q == ne_eff)
					state_d = ST_IDLE;
				else
					state_d = ST_AV_RD;
			end
			ST_AV_RD: begin
				div_dividend = {{(ACC_W-AVG_W){sum_q[AVG_W-1]}}, sum_q};
				div_divisor  = SUM_W'(npe_eff);
				if (k_q == npe_eff) begin
					div_start = 1'b1;
					state_d   = ST_AV_DIV;
				end else begin
					cn_re   = 1'b1;
					state_d = ST_AV_ID;
				end
			end
			ST_AV_ID: begin
				na_raddr = NA_W'(cn_rdata);
				if (cn_id_ok) begin
					na_re   = 1'b1;
					state_d = ST_AV_ADD;
				end else
					state_d = ST_AV_RD;
			end
			ST_AV_ADD: state_d = ST_AV_RD;
			ST_AV_DIV: begin
				if (div_st.done) begin
					res_we  = 1'b1;
					state_d = ST_AV_EL;
				end
			end
			// hand the read result to the output register
			ST_RD_OUT: begin
				if (!out_valid_q || !out_stall)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLR;
		else
			state_q <= state_d;
	end

	// counters and sweep limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_n_q   <= '0;
			cnt_e_q   <= '0;
			k_q       <= '0;
			clr_lim_q <= NC_W'(MAX_NODES);
		end else begin
			case (state_q)
				ST_CLR, ST_CZ, ST_NM_RD: begin
					if (state_d == state_q)
						cnt_n_q <= cnt_n_q + 1'b1;
					else if (state_q == ST_CZ) begin
						cnt_n_q <= '0;
						cnt_e_q <= '0;
						k_q     <= '0;
					end else if (state_q == ST_NM_RD)
						cnt_e_q <= '0;
				end
				ST_IDLE: begin
					cnt_n_q   <= '0;
					k_q       <= '0;
					clr_lim_q <= nn_eff;
				end
				ST_ADD_CONN: k_q <= (state_d == ST_ADD_RD) ? '0 : k_q + 1'b1;
				ST_ADD_RD: begin
					if (state_d == ST_ADD_RD)
						k_q <= k_q + 1'b1;
				end
				ST_ADD_UPD, ST_CK_UPD, ST_AV_ADD: k_q <= k_q + 1'b1;
				ST_CE_RD: k_q <= '0;
				ST_CK_RD: begin
					if (state_d == ST_CE_RD)
						cnt_e_q <= cnt_e_q + 1'b1;
				end
				ST_CK_ID, ST_AV_ID: begin
					if (!cn_id_ok)
						k_q <= k_q + 1'b1;
				end
				ST_NM_CHK: begin
					if (state_d == ST_NM_RD)
						cnt_n_q <= cnt_n_q + 1'b1;
				end
				ST_NM_DIV: begin
					if (div_st.done)
						cnt_n_q <= cnt_n_q + 1'b1;
				end
				ST_AV_EL: k_q <= '0;
				ST_AV_DIV: begin
					if (div_st.done)
						cnt_e_q <= cnt_e_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					elem_q    <= element_index;
					value_q   <= value;
					rd_bad_q  <= !in_elem_ok;
					node_q[0] <= node_0;
					node_q[1] <= node_1;
					node_q[2] <= node_2;
					node_q[3] <= node_3;
					node_q[4] <= node_4;
					node_q[5] <= node_5;
					node_q[6] <= node_6;
					node_q[7] <= node_7;
				end
			end
			ST_CE_MUL: p_q <= ACC_W'($signed(vol_rdata) * $signed(jac_rdata));
			ST_CK_ID: id_q <= cn_rdata;
			ST_AV_EL: sum_q <= '0;
			ST_AV_ID: begin
				if (!cn_id_ok)
					sum_q <= sum_q + {{(AVG_W-VAL_W){ONE_Q24[VAL_W-1]}}, ONE_Q24};
			end
			ST_AV_ADD:
				sum_q <= sum_q + {{(AVG_W-VAL_W){na_rdata[VAL_W-1]}}, na_rdata[VAL_W-1:0]};
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == ST_RD_OUT && state_d == ST_IDLE)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD_OUT && state_d == ST_IDLE)
			out_data_q <= rd_bad_q ? '0 : res_rdata;
	end

	assign in_stall          = (state_q != ST_IDLE);
	assign out_valid         = out_valid_q;
	assign averaged_jacobian = out_data_q;

	// storage
	anj_ram #(.W(NODE_W), .D(CD)) u_conn (
		.clk(clk), .we(cn_we), .waddr(cn_waddr), .wdata(cn_wdata),
		.re(cn_re), .raddr(cn_raddr), .rdata(cn_rdata)
	);

	anj_ram #(.W(VAL_W), .D(MAX_ELEMENTS)) u_vol (
		.clk(clk), .we(vol_we), .waddr(ej_waddr), .wdata(value),
		.re(ej_re), .raddr(ej_raddr), .rdata(vol_rdata)
	);

	anj_ram #(.W(VAL_W), .D(MAX_ELEMENTS)) u_jac (
		.clk(clk), .we(jac_we), .waddr(ej_waddr), .wdata(value),
		.re(ej_re), .raddr(ej_raddr), .rdata(jac_rdata)
	);

	anj_ram #(.W(VAL_W), .D(MAX_ELEMENTS)) u_res (
		.clk(clk), .we(res_we), .waddr(res_waddr), .wdata(div_quot),
		.re(res_re), .raddr(res_raddr), .rdata(res_rdata)
	);

	anj_ram #(.W(SUM_W), .D(MAX_NODES)) u_nsum (
		.clk(clk), .we(ns_we), .waddr(ns_waddr), .wdata(ns_wdata),
		.re(ns_re), .raddr(ns_raddr), .rdata(ns_rdata)
	);

	anj_ram #(.W(ACC_W), .D(MAX_NODES)) u_nacc (
		.clk(clk), .we(na_we), .waddr(na_waddr), .wdata(na_wdata),
		.re(na_re), .raddr(na_raddr), .rdata(na_rdata)
	);

	anj_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(div_divisor), .stat(div_st), .quot(div_quot)
	);

`ifndef SYNTHESIS
	// a read transaction always moves to the output handoff
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && command == CMD_READ |=> state_q == ST_RD_OUT)
		else $error("read did not reach output handoff");

	// a blocked handoff waits without losing the result
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD_OUT && out_valid_q && out_stall |=> state_q == ST_RD_OUT)
		else $error("read result dropped while output stalled");

	// the shared divider is never restarted while busy
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy)
		else $error("divider started while busy");

	// accumulator update only follows its id fetch
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CK_UPD |-> $past(state_q) == ST_CK_ID)
		else $error("accumulator update out of order");
`endif

endmodule
